@@ hdl/speed_kalman_filter_macros.svh @@
// Assertion macros for the speed Kalman filter.
// Used by the top level; no other dependencies.
`ifndef SPEED_KALMAN_FILTER_MACROS_SVH
`define SPEED_KALMAN_FILTER_MACROS_SVH
// Assert that a condition implies a consequence in the same cycle.
`define SKF_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);
// Assert that a condition implies a consequence in the next cycle.
`define SKF_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);
`endif

@@ hdl/skf_pkg.sv @@
// Package for the speed Kalman filter: register indexes and field widths.
// No dependencies.
package skf_pkg;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDataBits = 31;
  localparam logic [CfgIdxBits-1:0] RegTimeStep = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegProcNoise = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegMeasNoise = 2'd2;

  typedef struct packed {
    logic signed [31:0] acceleration;
    logic signed [31:0] measured_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] speed_out;
    logic [30:0]        variance_out;
    logic signed [31:0] position_out;
  } out_item_t;

  // Control between the sequencer and the divider.
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;
endpackage

@@ hdl/skf_stream_if.sv @@
// Valid/ready channel carrying one payload item.
// Depends on no package; payload type is a parameter.
interface skf_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/skf_div.sv @@
// Bit-serial gain divider: q = |n|*2^FB / d, saturated, sign of n.
// Uses skf_pkg for the control struct.
module skf_div import skf_pkg::*; #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRACTION_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [WORD_BITS-1:0] num_i,
  input  logic signed [WORD_BITS-1:0] den_i,
  output div_ctrl_t                   ctrl_o,
  output logic signed [WORD_BITS-1:0] quo_o
);
  localparam int unsigned NB = WORD_BITS + FRACTION_BITS;
  localparam int unsigned CB = $clog2(NB + 1);
  localparam logic [NB:0] WMaxQ = {{(FRACTION_BITS + 2){1'b0}}, {(WORD_BITS-1){1'b1}}};

  logic [NB-1:0] num_q, num_d;
  logic [WORD_BITS:0] rem_q, rem_d;
  logic [NB:0] quo_q, quo_d;
  logic [WORD_BITS-1:0] den_q, den_d;
  logic neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [CB-1:0] cnt_q, cnt_d;
  logic [WORD_BITS:0] shifted;
  logic [WORD_BITS-1:0] nmag;

  // Restoring long division, one quotient bit per cycle.
  always_comb begin
    num_d = num_q; rem_d = rem_q; quo_d = quo_q; den_d = den_q;
    neg_d = neg_q; busy_d = busy_q; done_d = 1'b0; cnt_d = cnt_q;
    nmag = num_i[WORD_BITS-1] ? WORD_BITS'(-num_i) : WORD_BITS'(num_i);
    shifted = {rem_q[WORD_BITS-1:0], num_q[NB-1]};
    if (start_i) begin
      num_d = {nmag, {FRACTION_BITS{1'b0}}};
      rem_d = '0; quo_d = '0; den_d = den_i;
      neg_d = num_i[WORD_BITS-1]; busy_d = 1'b1; cnt_d = '0;
    end else if (busy_q) begin
      num_d = {num_q[NB-2:0], 1'b0};
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
        quo_d = {quo_q[NB-1:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[NB-1:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CB'(NB - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end

  logic [WORD_BITS-1:0] qsat;
  assign qsat = (quo_q > WMaxQ) ? WMaxQ[WORD_BITS-1:0] : quo_q[WORD_BITS-1:0];
  assign quo_o = neg_q ? WORD_BITS'(-qsat) : qsat;
  assign ctrl_o = '{start: start_i, busy: busy_q, done: done_q};
endmodule

@@ hdl/speed_kalman_filter.sv @@
// Speed Kalman filter top level: sequencer, shared multiplier, state.
// Depends on skf_pkg, skf_stream_if, skf_div and the assertion macros.
//
// Usage: items arrive on in_ch (acceleration, measured speed); each gives
// exactly one result item on out_ch (speed, speed variance, position).
// Registers time_step (0), process_noise (1) and measurement_noise (2) are
// written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// One shared multiply-round-saturate unit runs the twelve products, each as
// a multiply step followed by a round-and-accumulate step, and a bit-serial
// divider produces each of the two gains (start, one quotient bit per cycle,
// then the finish). With a receiver that takes the result at once, the next
// item can be accepted in the following cycle; one item is in flight at a
// time. The result sits in an output register; in_ch stays not ready until
// it is taken, so a stalled receiver simply holds the filter.
// Reset zeros state and covariance and loads the default registers.
`include "speed_kalman_filter_macros.svh"
module speed_kalman_filter import skf_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 24,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  skf_stream_if.sink             in_ch,
  skf_stream_if.source           out_ch
);
  localparam int unsigned W = WORD_BITS;
  localparam int unsigned PW = 2 * W;
  localparam logic signed [W-1:0] WMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMin = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_DIV0, S_DIV1, S_OUT} state_e;

  state_e state_q;
  logic [3:0] step_q;
  logic [CfgDataBits-1:0] dt_q, qn_q, rn_q;
  logic signed [W-1:0] pos_q, spd_q, p00_q, p10_q, p01_q, p11_q;
  logic signed [W-1:0] acc_q, z_q, v_q, e_q, k0_q, k1_q, c00_q;
  logic signed [W-1:0] dtw, qnw, rnw;
  logic signed [PW-1:0] prod_q;
  logic signed [W-1:0] ma, mb, addend, mres, sum;
  logic sub;
  out_item_t res_q;
  logic dstart;
  div_ctrl_t dctl;
  logic signed [W-1:0] dquo, dnum, sden;

  // Saturating helpers at word width.
  function automatic logic signed [W-1:0] sat_add(logic signed [W-1:0] a,
                                                  logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMin : WMax;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] reg_word(logic [CfgDataBits-1:0] v);
    if ({{(W+CfgDataBits){1'b0}}, v} > {{(CfgDataBits+1){1'b0}}, WMax[W-2:0]})
      return WMax;
    return W'(v);
  endfunction

  function automatic logic signed [W-1:0] in_word(logic signed [31:0] v);
    if (W >= 32) return W'(v);
    if (v > 32'(WMax)) return WMax;
    if (v < 32'(WMin)) return WMin;
    return W'(v);
  endfunction

  function automatic logic [31:0] out32(logic signed [W-1:0] x);
    if (W <= 32) return 32'(x);
    if (x > W'(32'sh7fffffff)) return 32'h7fffffff;
    if (x < W'(-64'sh80000000)) return 32'h80000000;
    return 32'(x);
  endfunction

  assign dtw = reg_word(dt_q);
  assign qnw = reg_word(qn_q);
  assign rnw = reg_word(rn_q);

  // Operand selection for each product step: result = addend +/- a*b.
  always_comb begin
    ma = dtw; mb = spd_q; addend = pos_q; sub = 1'b0;
    case (step_q)
      4'd0: begin ma = dtw; mb = spd_q; addend = pos_q; end
      4'd1: begin ma = dtw; mb = acc_q; addend = spd_q; end
      4'd2: begin ma = dtw; mb = p10_q; addend = p00_q; end
      4'd3: begin ma = dtw; mb = p11_q; addend = p01_q; end
      4'd4: begin ma = p01_q; mb = dtw; addend = p00_q; end
      4'd5: begin ma = p11_q; mb = dtw; addend = p10_q; end
      4'd6: begin ma = k0_q; mb = e_q; addend = pos_q; end
      4'd7: begin ma = k1_q; mb = e_q; addend = v_q; end
      4'd8: begin ma = k0_q; mb = p10_q; addend = c00_q; sub = 1'b1; end
      4'd9: begin ma = k1_q; mb = p10_q; addend = p10_q; sub = 1'b1; end
      4'd10: begin ma = k0_q; mb = p11_q; addend = p01_q; sub = 1'b1; end
      4'd11: begin ma = k1_q; mb = p11_q; addend = p11_q; sub = 1'b1; end
      default: ;
    endcase
  end

  // Round half away from zero on magnitude, then saturate.
  logic [PW-1:0] pmag, prnd;
  logic [PW-1:0] mscaled;
  logic pneg;
  always_comb begin
    pneg = prod_q[PW-1];
    pmag = pneg ? PW'(-prod_q) : PW'(prod_q);
    prnd = pmag + (PW'(1) << (FRACTION_BITS - 1));
    mscaled = prnd >> FRACTION_BITS;
    if (pneg) mres = (mscaled > PW'(WMax) + PW'(1)) ? WMin : W'(-mscaled);
    else mres = (mscaled > PW'(WMax)) ? WMax : W'(mscaled);
    sum = sat_add(addend, sub ? ((mres == WMin) ? WMax : -mres) : mres);
  end

  // sub of WMin: addend - WMin, handled via extra saturation below.
  logic signed [W-1:0] acc_res;
  always_comb begin
    acc_res = sum;
    if (sub && mres == WMin) acc_res = sat_add(sat_add(addend, WMax), W'(1));
  end

  logic signed [W-1:0] c11w, sw;
  assign c11w = p11_q;
  assign sw = sat_add(c11w, rnw);
  assign dnum = (state_q == S_DIV0 && !dctl.busy) ? p01_q : p11_q;
  assign sden = sw;

  skf_div #(.WORD_BITS(W), .FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(sden),
    .ctrl_o(dctl), .quo_o(dquo)
  );

  logic div_go_q;
  assign dstart = div_go_q;

  // Sequencer and registered state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; step_q <= '0; div_go_q <= 1'b0;
      dt_q <= 31'd335544; qn_q <= 31'd8389; rn_q <= 31'd218104;
      pos_q <= '0; spd_q <= '0; p00_q <= '0; p10_q <= '0; p01_q <= '0; p11_q <= '0;
      acc_q <= '0; z_q <= '0; v_q <= '0; e_q <= '0; k0_q <= '0; k1_q <= '0;
      c00_q <= '0; prod_q <= '0; res_q <= '0;
    end else begin
      div_go_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegTimeStep: dt_q <= cfg_data_i;
          RegProcNoise: qn_q <= cfg_data_i;
          RegMeasNoise: rn_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: if (in_ch.valid) begin
          acc_q <= in_word(in_ch.data.acceleration);
          z_q <= in_word(in_ch.data.measured_speed);
          step_q <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q <= PW'(ma) * PW'(mb);
          state_q <= S_ACC;
        end
        S_ACC: begin
          state_q <= S_MUL;
          step_q <= step_q + 4'd1;
          case (step_q)
            4'd0: pos_q <= acc_res;
            4'd1: v_q <= acc_res;
            4'd2: p00_q <= acc_res;
            4'd3: p01_q <= acc_res;
            4'd4: c00_q <= acc_res;
            4'd5: begin
              p10_q <= acc_res;
              p11_q <= sat_add(p11_q, qnw);
              if (v_q == WMin) e_q <= sat_add(sat_add(z_q, WMax), W'(1));
              else e_q <= sat_add(z_q, -v_q);
              state_q <= S_DIV0;
              div_go_q <= 1'b1;
            end
            4'd6: pos_q <= acc_res;
            4'd7: spd_q <= acc_res;
            4'd8: p00_q <= acc_res;
            4'd9: p10_q <= acc_res;
            4'd10: p01_q <= acc_res;
            default: begin
              p11_q <= acc_res;
              state_q <= S_OUT;
              res_q.speed_out <= out32(spd_q);
              res_q.position_out <= out32(pos_q);
              res_q.variance_out <= acc_res[W-1] ? '0 :
                ((W > 31 && acc_res > W'(32'sh7fffffff)) ? 31'h7fffffff : 31'(acc_res));
            end
          endcase
        end
        S_DIV0: if (dctl.done) begin
          k0_q <= (sw > 0) ? dquo : '0;
          div_go_q <= 1'b1;
          state_q <= S_DIV1;
        end
        S_DIV1: if (dctl.done) begin
          k1_q <= (sw > 0) ? dquo : '0;
          state_q <= S_MUL;
        end
        S_OUT: if (out_ch.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready = (state_q == S_IDLE);
  assign out_ch.valid = (state_q == S_OUT);
  assign out_ch.data = res_q;

  `SKF_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, in_ch.ready, !out_ch.valid, "ready while result pending")
  `SKF_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_ch.valid && in_ch.ready, state_q == S_MUL, "accept did not start work")
  `SKF_ASSERT_IMP(a_div_idle, clk_i, rst_ni, state_q == S_MUL || state_q == S_ACC, !dctl.busy, "divider busy during products")
endmodule

@@ verif/speed_kalman_filter_test.sv @@
// Self-checking bench for the speed Kalman filter: drives acceleration and speed
// items, predicts each result with a fixed-point filter model and checks it.
// Depends on skf_pkg, skf_stream_if and speed_kalman_filter.
module speed_kalman_filter_test;
  import skf_pkg::*;

  localparam int unsigned FracBits = 24;
  localparam longint WordMax = 64'sd2147483647;
  localparam longint WordMin = -64'sd2147483648;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned RandItems = 1250;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = RegTimeStep;
  logic [CfgDataBits-1:0] cfg_data_i = '0;

  skf_stream_if #(.payload_t(in_item_t)) in_ch ();
  skf_stream_if #(.payload_t(out_item_t)) out_ch ();

  speed_kalman_filter u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Filter state and registers as the bench sees them.
  longint pos_est, speed_est;
  longint cov[4];
  longint dt_reg, qn_reg, rn_reg;
  out_item_t expected_q[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit in_done = 1'b0;

  function automatic longint clamp_word(longint x);
    if (x > WordMax) return WordMax;
    if (x < WordMin) return WordMin;
    return x;
  endfunction

  // Q8.24 product, rounded half away from zero, saturated.
  function automatic longint qmul(longint a, longint b);
    logic signed [127:0] prod;
    logic [127:0] m;
    prod = 128'(signed'(a)) * 128'(signed'(b));
    m = prod < 0 ? -prod : prod;
    m = (m + (128'd1 << (FracBits - 1))) >> FracBits;
    if (prod < 0) return (m > 128'(WordMax) + 1) ? WordMin : -longint'(m);
    return (m > 128'(WordMax)) ? WordMax : longint'(m);
  endfunction

  // Gain quotient |n| * 2^24 / d, truncated, magnitude saturated.
  function automatic longint qdiv(longint n, longint d);
    logic [127:0] q;
    q = (128'(n < 0 ? -n : n) << FracBits) / 128'(d);
    if (q > 128'(WordMax)) q = 128'(WordMax);
    return n < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic void filter_reset();
    pos_est = 0;
    speed_est = 0;
    foreach (cov[i]) cov[i] = 0;
    dt_reg = 335544;
    qn_reg = 8389;
    rn_reg = 218104;
  endfunction

  // One predict and update step; returns the expected result item.
  function automatic out_item_t filter_step(in_item_t it);
    longint p, v, m00, m01, m10, m11, c00, c10, c01, c11, e, s, k0, k1, var_p;
    out_item_t r;
    p = clamp_word(pos_est + qmul(dt_reg, speed_est));
    v = clamp_word(speed_est + qmul(dt_reg, longint'(it.acceleration)));
    m00 = clamp_word(cov[0] + qmul(dt_reg, cov[1]));
    m01 = clamp_word(cov[2] + qmul(dt_reg, cov[3]));
    m10 = cov[1];
    m11 = cov[3];
    c00 = clamp_word(m00 + qmul(m01, dt_reg));
    c10 = clamp_word(m10 + qmul(m11, dt_reg));
    c01 = m01;
    c11 = clamp_word(m11 + qn_reg);
    e = clamp_word(longint'(it.measured_speed) - v);
    s = clamp_word(c11 + rn_reg);
    k0 = 0;
    k1 = 0;
    if (s > 0) begin
      k0 = qdiv(c01, s);
      k1 = qdiv(c11, s);
    end
    pos_est = clamp_word(p + qmul(k0, e));
    speed_est = clamp_word(v + qmul(k1, e));
    cov[0] = clamp_word(c00 - qmul(k0, c10));
    cov[1] = clamp_word(c10 - qmul(k1, c10));
    cov[2] = clamp_word(c01 - qmul(k0, c11));
    cov[3] = clamp_word(c11 - qmul(k1, c11));
    var_p = cov[3] < 0 ? 0 : cov[3];
    r.speed_out = speed_est[31:0];
    r.variance_out = var_p[30:0];
    r.position_out = pos_est[31:0];
    return r;
  endfunction

  // Directed rows; a known result is typed in where check_known is set.
  typedef struct {
    in_item_t  item;
    bit        check_known;
    out_item_t known;
  } stim_row_t;

  stim_row_t dir_rows[$];

  // Valid stays high into the next item when there is no gap.
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_q.push_back(filter_step(it));
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, longint value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[30:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegTimeStep) dt_reg = value[30:0];
    else if (idx == RegProcNoise) qn_reg = value[30:0];
    else rn_reg = value[30:0];
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic in_item_t rand_item(int unsigned mode);
    in_item_t it;
    // Mostly realistic small values, sometimes full-range noise.
    if (mode < 7) begin
      it.acceleration = $signed($urandom_range(0, 1 << 26)) - (1 <<< 25);
      it.measured_speed = $signed($urandom_range(0, 1 << 28)) - (1 <<< 27);
    end else begin
      it.acceleration = $urandom();
      it.measured_speed = $urandom();
    end
    return it;
  endfunction

  // Sender: directed table, zero and extreme register settings, then random phases with register changes.
  initial begin
    stim_row_t row;
    in_item_t it;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    filter_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With zero state and inputs, the first result is zero speed and position.
    row.item = '0;
    row.check_known = 1'b1;
    row.known = '0;
    row.known.variance_out = 31'(qmul(8389, qdiv(8389 * 0 + 8389, 8389 + 218104)) == 0
                                ? 0 : 8389 - qmul(qdiv(8389, 226493), 8389));
    dir_rows.push_back(row);
    row.check_known = 1'b0;
    row.item.acceleration = 32'sh7fffffff; row.item.measured_speed = 32'sh7fffffff;
    dir_rows.push_back(row);
    row.item.acceleration = 32'sh80000000; row.item.measured_speed = 32'sh80000000;
    dir_rows.push_back(row);
    row.item.acceleration = 32'sh7fffffff; row.item.measured_speed = 32'sh80000000;
    dir_rows.push_back(row);
    row.item.acceleration = 32'sh80000000; row.item.measured_speed = 32'sh7fffffff;
    dir_rows.push_back(row);
    row.item.acceleration = 32'sh01000000; row.item.measured_speed = 32'sh00000000;
    dir_rows.push_back(row);
    row.item.acceleration = -32'sh01000000; row.item.measured_speed = 32'shffffffff;
    dir_rows.push_back(row);
    row.item.acceleration = 32'sh00000001; row.item.measured_speed = 32'sh00000001;
    dir_rows.push_back(row);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].check_known) begin
        send_item(dir_rows[i].item);
        void'(expected_q.pop_back());
        expected_q.push_back(dir_rows[i].known);
      end else begin
        send_item(dir_rows[i].item);
      end
    end
    wait_drained();

    // Zero registers: no motion step and no noise, gains come from the
    // covariance that is left over.
    write_reg(RegTimeStep, 0);
    write_reg(RegProcNoise, 0);
    write_reg(RegMeasNoise, 0);
    for (int i = 0; i < 4; i++) send_item(rand_item(8));
    wait_drained();

    // Extreme register settings.
    write_reg(RegTimeStep, 64'h7fffffff);
    write_reg(RegProcNoise, 64'h7fffffff);
    write_reg(RegMeasNoise, 64'h7fffffff);
    for (int i = 0; i < 6; i++) send_item(rand_item(i));
    wait_drained();
    write_reg(RegMeasNoise, 1);
    write_reg(RegProcNoise, 1);
    for (int i = 0; i < 6; i++) send_item(rand_item(i + 3));
    wait_drained();

    // Random phases, each with a fresh setting.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 3)
        0: begin
          write_reg(RegTimeStep, 335544);
          write_reg(RegProcNoise, 8389);
          write_reg(RegMeasNoise, 218104);
        end
        1: begin
          write_reg(RegTimeStep, $urandom_range(1, 1 << 25));
          write_reg(RegProcNoise, $urandom_range(0, 1 << 24));
          write_reg(RegMeasNoise, $urandom_range(1, 1 << 26));
        end
        default: begin
          write_reg(RegTimeStep, $urandom() >> 1);
          write_reg(RegProcNoise, $urandom() >> 1);
          write_reg(RegMeasNoise, $urandom() >> 1);
        end
      endcase
      for (int i = 0; i < RandItems / 10; i++) begin
        it = rand_item($urandom_range(0, 9));
        send_item(it);
      end
      wait_drained();
    end
    in_done = 1'b1;
  end

  // Receiver: random stalls, including stretches of constant readiness.
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // Result check against the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item %p", out_ch.data);
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.speed_out !== out_ch.data.speed_out ||
            exp_r.variance_out !== out_ch.data.variance_out ||
            exp_r.position_out !== out_ch.data.position_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: expected %p, got %p", exp_r, out_ch.data);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item, and end of run.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (in_done) begin
      if (mismatches == 0 && expected_q.size() == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end
endmodule
